// ----- hdl/wvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvm_pkg
// shared types, opcodes, status codes and sequencer states of the word vm core
// ----------------------------------------------------------------------------
package wvm_pkg;

    localparam int ADDR_W    = 15;
    localparam int WORD_W    = 16;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t ADDR_MASK = 16'h7fff;
    localparam word_t REG_LIMIT = 16'h8007;

    // opcodes
    localparam word_t OP_HALT = 16'd0;
    localparam word_t OP_SET  = 16'd1;
    localparam word_t OP_PUSH = 16'd2;
    localparam word_t OP_POP  = 16'd3;
    localparam word_t OP_EQ   = 16'd4;
    localparam word_t OP_GT   = 16'd5;
    localparam word_t OP_JMP  = 16'd6;
    localparam word_t OP_JT   = 16'd7;
    localparam word_t OP_JF   = 16'd8;
    localparam word_t OP_ADD  = 16'd9;
    localparam word_t OP_MULT = 16'd10;
    localparam word_t OP_MOD  = 16'd11;
    localparam word_t OP_AND  = 16'd12;
    localparam word_t OP_OR   = 16'd13;
    localparam word_t OP_NOT  = 16'd14;
    localparam word_t OP_RMEM = 16'd15;
    localparam word_t OP_WMEM = 16'd16;
    localparam word_t OP_CALL = 16'd17;
    localparam word_t OP_RET  = 16'd18;
    localparam word_t OP_OUT  = 16'd19;
    localparam word_t OP_IN   = 16'd20;
    localparam word_t OP_NOOP = 16'd21;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WAIT_IN   = 3'd1;
    localparam logic [2:0] ST_POP_EMPTY = 3'd2;
    localparam logic [2:0] ST_STK_FULL  = 3'd3;
    localparam logic [2:0] ST_BAD_OPND  = 3'd4;
    localparam logic [2:0] ST_MOD_ZERO  = 3'd5;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_FETCH = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_MEM   = 8'b0010_0000,
        S_STK   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_req_t;

    function automatic logic [1:0] operand_count(word_t op);
        logic [1:0] n;
        case (op)
            OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM:           n = 2'd2;
            OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN:          n = 2'd1;
            OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR:     n = 2'd3;
            default:                                                  n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/word_vm_instruction_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_vm_instruction_step
// 16-bit word vm core: loads program words or executes one instruction per
// transaction, with 32k-word program memory, eight registers and call stack
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata (40b), s_tuser (func)
// m_        out  m_tvalid/m_tready  m_tdata (32b)
// cfg_      in   cfg_wr_en          cfg_wr_data (start_pc)
//
// a load passes idle and finish; an execute passes idle, fetch of the opcode
// and operands, exec, a memory read (rmem, pop, ret) or serial divide (mod), finish
// after reset a clearing pass zeroes program memory and takes no input
// s_tready is high only while the sequencer idles; a finished result waits in
// the output register so the next transaction is taken while m_tready is low
// ----------------------------------------------------------------------------
module word_vm_instruction_step #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,      // start_pc
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,          // load_address, load_data, char_valid, in_char
    input  logic [0:0]  s_tuser,          // func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata           // out_valid, out_char, halted, status, pc_now
);
    import wvm_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // input fields
    logic        in_func;
    logic [14:0] in_load_addr;
    word_t       in_load_data;
    logic        in_char_valid;
    logic [7:0]  in_char;

    assign in_func       = s_tuser[0];
    assign in_load_addr  = s_tdata[14:0];
    assign in_load_data  = s_tdata[30:15];
    assign in_char_valid = s_tdata[31];
    assign in_char       = s_tdata[39:32];

    // state
    state_t            state_reg, state_next;
    logic [14:0]       clr_reg, clr_next;
    logic              started_reg, started_next;
    logic [14:0]       pc_reg, pc_next;
    logic              stopped_reg, stopped_next;
    logic [2:0]        code_reg, code_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    word_t             op_reg, op_next;
    logic [1:0]        n_reg, n_next;
    logic [1:0]        idx_reg, idx_next;
    word_t             opw_reg [3];
    word_t             opw_next [3];
    word_t             val_reg [3];
    word_t             val_next [3];
    logic              res_out_reg, res_out_next;
    logic [7:0]        res_char_reg, res_char_next;
    logic              res_wait_reg, res_wait_next;
    logic              char_ok_reg, char_ok_next;
    logic [7:0]        char_reg, char_next;
    logic              m_valid_reg, m_valid_next;
    logic [27:0]       m_data_reg, m_data_next;
    word_t             regs [8];

    // program memory
    word_t             pmem [32768];
    word_t             mem_rdata_reg;
    logic [14:0]       mem_raddr;
    logic              mem_we;
    logic [14:0]       mem_waddr;
    word_t             mem_wdata;

    // register file write port
    logic              reg_we;
    logic [2:0]        reg_waddr;
    word_t             reg_wdata;

    // stack, divider, alu
    stk_req_t          stk_req;
    logic [SP_W-1:0]   stk_addr;
    word_t             stk_wdata;
    word_t             stk_rdata;
    logic              div_start;
    logic              div_done;
    word_t             div_rem;
    word_t             alu_res;

    // fetch helpers
    word_t             fetch_val;
    logic [14:0]       fetch_addr;
    logic [14:0]       next_pc;
    logic [CNT_W-1:0]  cnt_dec;
    logic              stk_full;
    logic              s_fire;

    assign s_fire     = s_tvalid && s_tready;
    assign fetch_val  = (mem_rdata_reg <= ADDR_MASK) ? mem_rdata_reg : regs[mem_rdata_reg[2:0]];
    assign fetch_addr = pc_reg + {13'd0, idx_reg} + 15'd1;
    assign next_pc    = pc_reg + {13'd0, n_reg} + 15'd1;
    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign stk_full   = (cnt_reg == CNT_W'(STACK_DEPTH));

    wvm_alu u_alu (
        .op     (op_reg),
        .b      (val_reg[1]),
        .c      (val_reg[2]),
        .result (alu_res)
    );

    wvm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (val_reg[1]),
        .divisor   (val_reg[2]),
        .done      (div_done),
        .remainder (div_rem)
    );

    wvm_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (SP_W)
    ) u_stack (
        .aclk  (aclk),
        .req   (stk_req),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        started_next  = started_reg;
        pc_next       = pc_reg;
        stopped_next  = stopped_reg;
        code_next     = code_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        opw_next      = opw_reg;
        val_next      = val_reg;
        res_out_next  = res_out_reg;
        res_char_next = res_char_reg;
        res_wait_next = res_wait_reg;
        char_ok_next  = char_ok_reg;
        char_next     = char_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        mem_raddr = pc_reg;
        mem_we    = 1'b0;
        mem_waddr = in_load_addr;
        mem_wdata = in_load_data;
        reg_we    = 1'b0;
        reg_waddr = opw_reg[0][2:0];
        reg_wdata = val_reg[1];
        stk_req   = '0;
        stk_addr  = cnt_reg[SP_W-1:0];
        stk_wdata = val_reg[0];
        div_start = 1'b0;

        // result register drains independently of the sequencer
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // start_pc only lands in the pc before the first execute
        if (cfg_wr_en && !started_reg) begin
            pc_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 15'd1;
                if (clr_reg == 15'h7fff) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    res_out_next  = 1'b0;
                    res_char_next = '0;
                    res_wait_next = 1'b0;
                    char_ok_next  = in_char_valid;
                    char_next     = in_char;
                    if (!in_func) begin
                        // program word load
                        mem_we     = 1'b1;
                        state_next = S_FIN;
                    end else if (stopped_reg) begin
                        state_next = S_FIN;
                    end else begin
                        started_next = 1'b1;
                        idx_next     = 2'd0;
                        state_next   = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                // one word per cycle: opcode first, then operands
                mem_raddr = fetch_addr;
                if (idx_reg == 2'd0) begin
                    op_next  = mem_rdata_reg;
                    n_next   = operand_count(mem_rdata_reg);
                    idx_next = 2'd1;
                    if (operand_count(mem_rdata_reg) == 2'd0) begin
                        state_next = S_EXEC;
                    end
                end else begin
                    opw_next[idx_reg - 2'd1] = mem_rdata_reg;
                    val_next[idx_reg - 2'd1] = fetch_val;
                    idx_next = idx_reg + 2'd1;
                    if (mem_rdata_reg > REG_LIMIT) begin
                        stopped_next = 1'b1;
                        code_next    = ST_BAD_OPND;
                        state_next   = S_FIN;
                    end else if (idx_reg == n_reg) begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
                reg_we     = opw_reg[0][15];
                reg_wdata  = alu_res;
                case (op_reg)
                    OP_HALT: begin
                        reg_we       = 1'b0;
                        stopped_next = 1'b1;
                        code_next    = ST_OK;
                    end
                    OP_SET: begin
                        reg_wdata = val_reg[1];
                        pc_next   = next_pc;
                    end
                    OP_PUSH: begin
                        reg_we = 1'b0;
                        if (stk_full) begin
                            stopped_next = 1'b1;
                            code_next    = ST_STK_FULL;
                        end else begin
                            stk_req.push = 1'b1;
                            cnt_next     = cnt_reg + CNT_W'(1);
                            pc_next      = next_pc;
                        end
                    end
                    OP_POP, OP_RET: begin
                        reg_we = 1'b0;
                        if (cnt_reg == '0) begin
                            stopped_next = 1'b1;
                            code_next    = (op_reg == OP_POP) ? ST_POP_EMPTY : ST_OK;
                        end else begin
                            stk_req.pop = 1'b1;
                            stk_addr    = cnt_dec[SP_W-1:0];
                            cnt_next    = cnt_dec;
                            state_next  = S_STK;
                        end
                    end
                    OP_JMP: begin
                        reg_we  = 1'b0;
                        pc_next = val_reg[0][14:0];
                    end
                    OP_JT: begin
                        reg_we  = 1'b0;
                        pc_next = (val_reg[0] != '0) ? val_reg[1][14:0] : next_pc;
                    end
                    OP_JF: begin
                        reg_we  = 1'b0;
                        pc_next = (val_reg[0] == '0) ? val_reg[1][14:0] : next_pc;
                    end
                    OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_AND, OP_OR, OP_NOT: begin
                        pc_next = next_pc;
                    end
                    OP_MOD: begin
                        reg_we = 1'b0;
                        if (val_reg[2] == '0) begin
                            stopped_next = 1'b1;
                            code_next    = ST_MOD_ZERO;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    OP_RMEM: begin
                        reg_we     = 1'b0;
                        mem_raddr  = val_reg[1][14:0];
                        state_next = S_MEM;
                    end
                    OP_WMEM: begin
                        reg_we    = 1'b0;
                        mem_we    = 1'b1;
                        mem_waddr = val_reg[0][14:0];
                        mem_wdata = val_reg[1];
                        pc_next   = next_pc;
                    end
                    OP_CALL: begin
                        reg_we = 1'b0;
                        if (stk_full) begin
                            stopped_next = 1'b1;
                            code_next    = ST_STK_FULL;
                        end else begin
                            stk_req.push = 1'b1;
                            stk_wdata    = {1'b0, next_pc};
                            cnt_next     = cnt_reg + CNT_W'(1);
                            pc_next      = val_reg[0][14:0];
                        end
                    end
                    OP_OUT: begin
                        reg_we        = 1'b0;
                        res_out_next  = 1'b1;
                        res_char_next = val_reg[0][7:0];
                        pc_next       = next_pc;
                    end
                    OP_IN: begin
                        // no character: retry later, pc holds
                        reg_we    = char_ok_reg && opw_reg[0][15];
                        reg_wdata = {8'd0, char_reg};
                        if (char_ok_reg) begin
                            pc_next = next_pc;
                        end else begin
                            res_wait_next = 1'b1;
                        end
                    end
                    default: begin
                        // noop and unknown opcodes
                        reg_we  = 1'b0;
                        pc_next = next_pc;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    reg_we     = opw_reg[0][15];
                    reg_wdata  = div_rem;
                    pc_next    = next_pc;
                    state_next = S_FIN;
                end
            end
            S_MEM: begin
                reg_we     = opw_reg[0][15];
                reg_wdata  = mem_rdata_reg;
                pc_next    = next_pc;
                state_next = S_FIN;
            end
            S_STK: begin
                if (op_reg == OP_POP) begin
                    reg_we    = opw_reg[0][15];
                    reg_wdata = stk_rdata;
                    pc_next   = next_pc;
                end else begin
                    pc_next = stk_rdata[14:0];
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                // wait for a free output register
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {pc_reg,
                                    stopped_reg ? code_reg
                                                : (res_wait_reg ? ST_WAIT_IN : ST_OK),
                                    stopped_reg, res_char_reg, res_out_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            started_reg <= 1'b0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
            code_reg    <= ST_OK;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            started_reg <= started_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            code_reg    <= code_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        n_reg        <= n_next;
        opw_reg      <= opw_next;
        val_reg      <= val_next;
        res_out_reg  <= res_out_next;
        res_char_reg <= res_char_next;
        res_wait_reg <= res_wait_next;
        char_ok_reg  <= char_ok_next;
        char_reg     <= char_next;
        m_data_reg   <= m_data_next;
    end

    // register file, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                regs[i] <= '0;
            end
        end else if (reg_we) begin
            regs[reg_waddr] <= reg_wdata;
        end
    end

    // program memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pmem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= pmem[mem_raddr];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg};

`ifndef ASSERT_OFF
    // stack never grows past its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a stopped machine stays stopped until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide wait");

    // no transaction is taken during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |=> !$past(s_fire))
        else $error("transaction accepted while clearing");
`endif

endmodule

// ----- hdl/wvm_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvm_alu
// shared combinational arithmetic, logic and compare unit
// ----------------------------------------------------------------------------
module wvm_alu (
    input  wvm_pkg::word_t op,
    input  wvm_pkg::word_t b,
    input  wvm_pkg::word_t c,
    output wvm_pkg::word_t result
);
    import wvm_pkg::*;

    logic [31:0] prod;
    logic [16:0] sum;

    assign prod = b * c;
    assign sum  = {1'b0, b} + {1'b0, c};

    always_comb begin
        case (op)
            OP_EQ:   result = {15'd0, b == c};
            OP_GT:   result = {15'd0, b > c};
            OP_ADD:  result = sum[15:0] & ADDR_MASK;
            OP_MULT: result = prod[15:0] & ADDR_MASK;
            OP_AND:  result = b & c;
            OP_OR:   result = b | c;
            OP_NOT:  result = ~b & ADDR_MASK;
            default: result = b;
        endcase
    end

endmodule

// ----- hdl/wvm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvm_div
// restoring divider, one remainder bit per cycle
// ----------------------------------------------------------------------------
module wvm_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  wvm_pkg::word_t dividend,
    input  wvm_pkg::word_t divisor,
    output logic           done,
    output wvm_pkg::word_t remainder
);
    import wvm_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    word_t       d_reg;
    word_t       r_reg;
    word_t       c_reg;
    logic [16:0] trial;
    word_t       r_next;

    assign trial  = {r_reg, d_reg[15]};
    assign r_next = (trial >= {1'b0, c_reg}) ? 16'(trial - {1'b0, c_reg}) : trial[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                d_reg    <= dividend;
                c_reg    <= divisor;
                r_reg    <= '0;
            end else if (busy_reg) begin
                r_reg   <= r_next;
                d_reg   <= {d_reg[14:0], 1'b0};
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = r_reg;

endmodule

// ----- hdl/wvm_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvm_stack
// call stack memory, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module wvm_stack #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               aclk,
    input  wvm_pkg::stk_req_t  req,
    input  logic [AW-1:0]      addr,
    input  wvm_pkg::word_t     wdata,
    output wvm_pkg::word_t     rdata
);
    import wvm_pkg::*;

    word_t mem [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.push) begin
            mem[addr] <= wdata;
        end
        if (req.pop) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the word vm core: programs are written into memory
// with load transactions and stepped with execute transactions, every result
// is checked against a cycle-free behavioral copy of the machine
// ----------------------------------------------------------------------------
module tb;
    import wvm_pkg::*;

    localparam int VM_STACK  = 256;
    localparam int IDLE_LIM  = 200000;   // covers the memory clearing pass
    localparam int DRAIN_CYC = 100;

    // operand words per opcode
    localparam int OPND_N [22] = '{0, 2, 1, 1, 3, 3, 1, 2, 2, 3, 3, 3,
                                   3, 3, 2, 2, 2, 1, 0, 1, 1, 0};

    // stop kinds for the closing test
    typedef enum int {
        END_HALT, END_RET_EMPTY, END_POP_EMPTY, END_STK_FULL, END_BAD_OPND, END_MOD_ZERO
    } end_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // load_address, load_data, char_valid, in_char
    logic [0:0]  s_tuser;     // func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // out_valid, out_char, halted, status, pc_now

    word_vm_instruction_step #(.STACK_DEPTH(VM_STACK)) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // machine copy used for prediction
    word_t       vm_mem [0:32767];
    word_t       vm_reg [0:7];
    word_t       vm_stk [0:VM_STACK-1];
    int          vm_sp;
    logic [14:0] vm_pc;
    logic [14:0] vm_start;
    bit          vm_stopped;
    bit          vm_started;
    logic [2:0]  vm_code;

    logic [31:0] step_results [$];   // predicted result words, oldest first
    int          fail_cnt;
    int          idle_cyc;
    bit          no_gaps;            // burst mode: no idling on either side
    int          stall_left;

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // behavioral machine
    // ------------------------------------------------------------------
    function automatic word_t opnd_val(word_t w);
        return (w <= ADDR_MASK) ? w : vm_reg[w[2:0]];
    endfunction

    function automatic void opnd_wr(word_t w, word_t v);
        if (w > ADDR_MASK) vm_reg[w[2:0]] = v;
    endfunction

    function automatic void vm_stop(logic [2:0] code);
        vm_stopped = 1'b1;
        vm_code    = code;
    endfunction

    // runs one instruction; returns out flag/char and the waiting-input flag
    task automatic vm_exec(input logic cv, input logic [7:0] ic,
                           output logic ov, output logic [7:0] oc, output logic wt);
        word_t       op;
        word_t       w [3];
        word_t       b;
        word_t       c;
        word_t       tgt;
        int          n;
        logic [14:0] nxt;
        ov = 1'b0;
        oc = '0;
        wt = 1'b0;
        op = vm_mem[vm_pc];
        n  = (op < 16'd22) ? OPND_N[op] : 0;
        w  = '{default: '0};
        for (int i = 0; i < n; i++) begin
            w[i] = vm_mem[15'(vm_pc + 1 + i)];
            if (w[i] > REG_LIMIT) begin
                vm_stop(ST_BAD_OPND);
                return;
            end
        end
        nxt = 15'(vm_pc + 1 + n);
        b   = opnd_val(w[1]);
        c   = opnd_val(w[2]);
        case (op)
            OP_HALT: begin
                vm_stop(ST_OK);
                return;
            end
            OP_SET:  opnd_wr(w[0], b);
            OP_PUSH: begin
                if (vm_sp >= VM_STACK) begin
                    vm_stop(ST_STK_FULL);
                    return;
                end
                vm_stk[vm_sp] = opnd_val(w[0]);
                vm_sp++;
            end
            OP_POP: begin
                if (vm_sp == 0) begin
                    vm_stop(ST_POP_EMPTY);
                    return;
                end
                vm_sp--;
                opnd_wr(w[0], vm_stk[vm_sp]);
            end
            OP_EQ:   opnd_wr(w[0], word_t'(b == c));
            OP_GT:   opnd_wr(w[0], word_t'(b > c));
            OP_JMP:  nxt = 15'(opnd_val(w[0]) & ADDR_MASK);
            OP_JT:   if (opnd_val(w[0]) != 0) nxt = b[14:0];
            OP_JF:   if (opnd_val(w[0]) == 0) nxt = b[14:0];
            OP_ADD:  opnd_wr(w[0], (b + c) & ADDR_MASK);
            OP_MULT: opnd_wr(w[0], word_t'(32'(b) * 32'(c)) & ADDR_MASK);
            OP_MOD: begin
                if (c == 0) begin
                    vm_stop(ST_MOD_ZERO);
                    return;
                end
                opnd_wr(w[0], b % c);
            end
            OP_AND:  opnd_wr(w[0], b & c);
            OP_OR:   opnd_wr(w[0], b | c);
            OP_NOT:  opnd_wr(w[0], ~b & ADDR_MASK);
            OP_RMEM: opnd_wr(w[0], vm_mem[b[14:0]]);
            OP_WMEM: vm_mem[opnd_val(w[0]) & ADDR_MASK] = b;
            OP_CALL: begin
                tgt = opnd_val(w[0]);
                if (vm_sp >= VM_STACK) begin
                    vm_stop(ST_STK_FULL);
                    return;
                end
                vm_stk[vm_sp] = word_t'(nxt);
                vm_sp++;
                nxt = tgt[14:0];
            end
            OP_RET: begin
                if (vm_sp == 0) begin
                    vm_stop(ST_OK);
                    return;
                end
                vm_sp--;
                nxt = vm_stk[vm_sp][14:0];
            end
            OP_OUT: begin
                ov = 1'b1;
                oc = 8'(opnd_val(w[0]));
            end
            OP_IN: begin
                if (!cv) begin
                    wt = 1'b1;
                    return;
                end
                opnd_wr(w[0], word_t'(ic));
            end
            default: ;
        endcase
        vm_pc = nxt;
    endtask

    // full step: returns the packed result word
    task automatic vm_step(input logic fn, input logic [39:0] d, output logic [31:0] r);
        logic       ov;
        logic [7:0] oc;
        logic       wt;
        logic [2:0] st;
        ov = 1'b0;
        oc = '0;
        wt = 1'b0;
        if (!fn) begin
            vm_mem[d[14:0]] = d[30:15];
        end else if (!vm_stopped) begin
            if (!vm_started) begin
                vm_started = 1'b1;
                vm_pc      = vm_start;
            end
            vm_exec(d[31], d[39:32], ov, oc, wt);
        end
        st = vm_stopped ? vm_code : (wt ? ST_WAIT_IN : ST_OK);
        r  = {4'b0, (vm_started ? vm_pc : vm_start), st, vm_stopped, oc, ov};
    endtask

    function automatic logic [14:0] cur_pc();
        return vm_started ? vm_pc : vm_start;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 19);
    endfunction

    // one input transaction, predicted at acceptance
    task automatic send_item(input logic fn, input logic [39:0] d);
        int          gap;
        logic [31:0] r;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= fn;
        s_tdata    <= d;
        do @(posedge aclk); while (!s_tready);
        vm_step(fn, d, r);
        step_results.push_back(r);
    endtask

    task automatic load_word(input logic [14:0] a, input word_t v);
        send_item(1'b0, {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), v, a});
    endtask

    // execute transaction with random filler in the load fields
    task automatic exec_step(input logic cv, input logic [7:0] ic);
        logic [30:0] junk;
        junk = 31'($urandom);
        send_item(1'b1, {ic, cv, junk});
    endtask

    // place one instruction at the current pc and run it
    task automatic run_instr(input word_t op, input word_t a, input word_t b, input word_t c,
                             input logic cv, input logic [7:0] ic);
        logic [14:0] p;
        int          n;
        p = cur_pc();
        n = (op < 16'd22) ? OPND_N[op] : 0;
        load_word(p, op);
        if (n > 0) load_word(15'(p + 1), a);
        if (n > 1) load_word(15'(p + 2), b);
        if (n > 2) load_word(15'(p + 3), c);
        exec_step(cv, ic);
    endtask

    // drops the input valid and waits until every predicted result has been checked
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (step_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_start_pc(input logic [14:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        vm_start = v;
        if (!vm_started) vm_pc = v;
    endtask

    function automatic word_t rand_opnd();
        case ($urandom_range(0, 3))
            0, 1:    return 16'h8000 | 16'($urandom_range(0, 7));
            2:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // start_pc before execution begins, loads report it as pc_now
    task automatic test_start_pc();
        write_start_pc(15'h7fff);
        load_word(15'h7fff, 16'hffff);
        write_start_pc(15'h0000);
        load_word(15'h0000, 16'h0000);
        write_start_pc(15'h7ffe);
    endtask

    // every opcode but halt at least once, with field extremes; operand words wrap past 0x7fff
    task automatic test_opcodes();
        run_instr(OP_SET,  16'h8000, 16'h7fff, 0, 0, 0);
        run_instr(OP_ADD,  16'h8001, 16'h8000, 16'd1, 0, 0);       // wraps to 0
        run_instr(OP_MULT, 16'h8002, 16'h8000, 16'h8000, 0, 0);
        run_instr(OP_NOT,  16'h8003, 16'h0000, 0, 0, 0);
        run_instr(OP_MOD,  16'h8004, 16'h8000, 16'd10, 0, 0);
        run_instr(OP_EQ,   16'h8005, 16'h8000, 16'h7fff, 0, 0);
        run_instr(OP_GT,   16'h8006, 16'h8000, 16'h8007, 0, 0);
        run_instr(OP_AND,  16'h8007, 16'h8003, 16'h5555, 0, 0);
        run_instr(OP_OR,   16'h8001, 16'h8007, 16'h2aaa, 0, 0);
        run_instr(OP_OUT,  16'h8000, 0, 0, 0, 0);
        run_instr(OP_IN,   16'h8002, 0, 0, 1'b0, 8'hff);           // waits
        exec_step(1'b1, 8'hff);                                    // retry consumes
        run_instr(OP_IN,   16'd7, 0, 0, 1'b1, 8'h5a);              // literal target
        run_instr(OP_PUSH, 16'h8000, 0, 0, 0, 0);
        run_instr(OP_POP,  16'h7fff, 0, 0, 0, 0);                  // literal target
        run_instr(OP_CALL, 16'd100, 0, 0, 0, 0);
        run_instr(OP_RET,  0, 0, 0, 0, 0);
        run_instr(OP_JT,   16'h8000, 16'd200, 0, 0, 0);
        run_instr(OP_JF,   16'h8000, 16'd300, 0, 0, 0);
        run_instr(OP_WMEM, 16'd500, 16'h8000, 0, 0, 0);
        run_instr(OP_RMEM, 16'h8003, 16'd500, 0, 0, 0);
        run_instr(OP_JMP,  16'h8000, 0, 0, 0, 0);                  // to 0x7fff
        run_instr(16'hffff, 0, 0, 0, 0, 0);                        // unknown opcode
        run_instr(OP_NOOP, 0, 0, 0, 0, 0);
    endtask

    // start_pc written after execution began must not matter
    task automatic test_late_start_pc();
        write_start_pc(15'h1234);
        run_instr(OP_OUT, 16'd65, 0, 0, 0, 0);
    endtask

    // random instructions that never stop the machine, with noise transactions
    task automatic test_random_program(input int items);
        int    sent;
        word_t op;
        word_t a;
        word_t b;
        word_t c;
        sent = 0;
        while (sent < items) begin
            no_gaps = ($urandom_range(0, 15) == 0) ? ~no_gaps : no_gaps;
            if ($urandom_range(0, 9) == 0) begin
                load_word(15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)));
                sent++;
            end else begin
                op = 16'($urandom_range(1, 23));
                if (op >= 16'd22) op = 16'($urandom_range(22, 65535));
                a = rand_opnd();
                b = rand_opnd();
                c = rand_opnd();
                if ((op == OP_PUSH || op == OP_CALL) && vm_sp >= VM_STACK) op = OP_NOOP;
                if (op == OP_POP && vm_sp == 0) op = OP_PUSH;
                if (op == OP_RET && vm_sp == 0) op = OP_NOOP;
                if (op == OP_MOD && opnd_val(c) == 0) c = 16'd1;
                run_instr(op, a, b, c, 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
                sent += 1 + ((op < 16'd22) ? OPND_N[op] : 0) + 1;
            end
        end
    endtask

    // one kind of stop per run, then stopped behavior
    task automatic test_stop();
        end_kind_t   k;
        word_t       bad;
        logic [14:0] p;
        k   = end_kind_t'($urandom_range(0, 5));
        bad = 16'($urandom_range(16'h8008, 16'hffff));
        if (k == END_RET_EMPTY || k == END_POP_EMPTY)
            while (vm_sp > 0) run_instr(OP_POP, rand_opnd(), 0, 0, 0, 0);
        case (k)
            END_HALT:      run_instr(OP_HALT, 0, 0, 0, 0, 0);
            END_RET_EMPTY: run_instr(OP_RET, 0, 0, 0, 0, 0);
            END_POP_EMPTY: run_instr(OP_POP, 16'h8000, 0, 0, 0, 0);
            END_STK_FULL: begin
                // a call to itself pushes one word per execute
                p = cur_pc();
                load_word(p, OP_CALL);
                load_word(15'(p + 1), word_t'(p));
                while (vm_sp < VM_STACK) exec_step(1'b0, 8'h00);
                if ($urandom_range(0, 1)) run_instr(OP_PUSH, 16'h8000, 0, 0, 0, 0);
                else run_instr(OP_CALL, 16'd0, 0, 0, 0, 0);
            end
            END_BAD_OPND:  run_instr(OP_ADD, 16'h8000, 16'h8001, bad, 0, 0);
            default: begin
                run_instr(OP_SET, 16'h8007, 16'd0, 0, 0, 0);
                run_instr(OP_MOD, 16'h8000, 16'h8001, 16'h8007, 0, 0);
            end
        endcase
        exec_step(1'b1, 8'h00);
        load_word(15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)));
        exec_step(1'b0, 8'h00);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        vm_mem     = '{default: '0};
        vm_reg     = '{default: '0};
        vm_stk     = '{default: '0};
        vm_sp      = 0;
        vm_pc      = '0;
        vm_start   = '0;
        vm_stopped = 1'b0;
        vm_started = 1'b0;
        vm_code    = ST_OK;
        no_gaps    = 1'b0;
        @(posedge aclk iff aresetn);
        test_start_pc();
        test_opcodes();
        test_late_start_pc();
        test_random_program(400);
        test_stop();
        wait_idle();
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls and checking
    // ------------------------------------------------------------------
    initial fail_cnt = 0;
    initial m_tready = 1'b0;
    initial stall_left = 0;

    task automatic report(input string fld, input logic [31:0] got, input logic [31:0] want);
        fail_cnt++;
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, fld, got, want);
    endtask

    always @(posedge aclk) begin
        logic [31:0] want;
        logic        rdy;
        if (aresetn && m_tvalid && m_tready) begin
            if (step_results.size() == 0) begin
                report("unexpected transaction", m_tdata, 32'h0);
            end else begin
                want = step_results.pop_front();
                if (m_tdata[0] !== want[0])         report("out_valid", m_tdata[0], want[0]);
                if (m_tdata[8:1] !== want[8:1])     report("out_char", m_tdata[8:1], want[8:1]);
                if (m_tdata[9] !== want[9])         report("halted", m_tdata[9], want[9]);
                if (m_tdata[12:10] !== want[12:10]) report("status", m_tdata[12:10], want[12:10]);
                if (m_tdata[27:13] !== want[27:13]) report("pc_now", m_tdata[27:13], want[27:13]);
            end
            stall_left = draw_gap();
        end else if (stall_left > 0) begin
            stall_left--;
        end
        rdy = (stall_left == 0);
        m_tready <= rdy;
    end

    // watchdog on cycles with no accepted transaction on either side
    initial idle_cyc = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= IDLE_LIM) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
